>>> hw/rtl/tcob_pkg.sv
package tcob_pkg;

  localparam int VALUE_BITS = 16;
  localparam int AMP_W      = VALUE_BITS + 1;
  localparam int NUM_W      = VALUE_BITS + 9;
  localparam int PROD_W     = VALUE_BITS + 12;
  localparam int DIV_STAGES = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = (VALUE_BITS > 8) ? VALUE_BITS : 8;

  localparam logic [AMP_W-1:0] ONE  = AMP_W'(64'd1 << VALUE_BITS);
  localparam logic [AMP_W-1:0] HALF = AMP_W'(64'd1 << (VALUE_BITS - 1));
  localparam logic [VALUE_BITS-1:0] THR_MAX =
    VALUE_BITS'(((64'd1 << VALUE_BITS) * 64'd95) / 64'd100);

  localparam logic [15:0] BLEND_RECIP = 16'd32897;
  localparam int          BLEND_SHIFT = 23;

  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OPACITY     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd2;

  // index 2 is red, 1 green, 0 blue
  typedef logic [2:0][7:0] rgb_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] sample_value;
    logic [7:0]            base_red;
    logic [7:0]            base_green;
    logic [7:0]            base_blue;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] overlay_alpha;
    logic       covered;
  } pixel_out_t;

  typedef struct packed {
    logic                  signed_mode;
    logic [7:0]            opacity;
    logic [VALUE_BITS-1:0] threshold;
  } cfg_t;

  typedef struct packed {
    logic [NUM_W-1:0] numer;
    rgb_t             color;
    rgb_t             base;
    logic             covered;
  } div_beat_t;

  typedef struct packed {
    logic [7:0] alpha;
    rgb_t       color;
    rgb_t       base;
    logic       covered;
  } blend_beat_t;

  function automatic rgb_t ramp_anchor(logic mode, logic [1:0] anchor);
    rgb_t c;
    case (anchor)
      2'd0:    c = mode ? {8'd43, 8'd108, 8'd255} : {8'd25, 8'd185, 8'd220};
      2'd1:    c = mode ? {8'd235, 8'd244, 8'd248} : {8'd255, 8'd221, 8'd72};
      2'd2:    c = mode ? {8'd255, 8'd72, 8'd88} : {8'd255, 8'd77, 8'd66};
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/tcob_front.sv
module tcob_front import tcob_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      in_valid,
  output logic      in_ready,
  input  pixel_in_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output div_beat_t out_data
);

  logic v1, v2, v3;
  logic en1, en2, en3;

  // stage 1 registers
  logic [AMP_W-1:0] diff1;
  logic [AMP_W-1:0] t1;
  logic             seg1;
  logic             cov1;
  rgb_t             base1;

  // stage 2 registers
  logic [NUM_W-1:0]                num2;
  logic signed [2:0][PROD_W-1:0]   prod2;
  rgb_t                            a2;
  rgb_t                            base2;
  logic                            cov2;

  // stage 3 registers
  div_beat_t beat3;

  logic [AMP_W-1:0] thr_ext;
  logic [AMP_W-1:0] den;
  logic [AMP_W-1:0] twice;
  logic [AMP_W-1:0] amp;
  logic [AMP_W-1:0] t_c;
  logic             seg_c;

  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  assign thr_ext = {1'b0, cfg.threshold};
  assign den     = ONE - thr_ext;
  assign twice   = {in_data.sample_value, 1'b0};

  always_comb begin
    if (cfg.signed_mode) begin
      amp = (twice >= ONE) ? (twice - ONE) : (ONE - twice);
    end else begin
      amp = {1'b0, in_data.sample_value};
    end
    seg_c = {1'b0, in_data.sample_value} > HALF;
    t_c   = seg_c ? (twice - ONE) : twice;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= in_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
    end
  end

  // stage 1: amplitude, threshold compare, ramp position
  always_ff @(posedge clk) begin
    if (en1) begin
      diff1 <= amp - thr_ext;
      cov1  <= amp > thr_ext;
      t1    <= t_c;
      seg1  <= seg_c;
      base1 <= {in_data.base_red, in_data.base_green, in_data.base_blue};
    end
  end

  // stage 2: alpha numerator and ramp products
  rgb_t                          a_c;
  rgb_t                          b_c;
  logic signed [2:0][PROD_W-1:0] prod_c;
  logic signed [9:0]             d_c;

  always_comb begin
    a_c = ramp_anchor(cfg.signed_mode, {1'b0, seg1});
    b_c = ramp_anchor(cfg.signed_mode, {1'b0, seg1} + 2'd1);
    d_c = '0;
    for (int k = 0; k < 3; k++) begin
      d_c       = $signed({2'b00, b_c[k]}) - $signed({2'b00, a_c[k]});
      prod_c[k] = PROD_W'($signed({1'b0, t1})) * PROD_W'(d_c);
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      num2  <= NUM_W'(cfg.opacity) * NUM_W'(diff1);
      prod2 <= prod_c;
      a2    <= a_c;
      base2 <= base1;
      cov2  <= cov1;
    end
  end

  // stage 3: rounded ramp colour and divider numerator
  rgb_t                    color_c;
  logic signed [PROD_W-1:0] s_c;

  always_comb begin
    s_c = '0;
    for (int k = 0; k < 3; k++) begin
      s_c = $signed(PROD_W'({a2[k], {VALUE_BITS{1'b0}}})) + prod2[k]
          + $signed(PROD_W'(HALF));
      color_c[k] = s_c[VALUE_BITS+7:VALUE_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      beat3.numer   <= (num2 << 1) + NUM_W'(den);
      beat3.color   <= color_c;
      beat3.base    <= base2;
      beat3.covered <= cov2;
    end
  end

  assign out_valid = v3;
  assign out_data  = beat3;

endmodule

>>> hw/rtl/tcob_div.sv
module tcob_div import tcob_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  div_beat_t   in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output blend_beat_t out_data
);

  logic [DIV_STAGES-1:0] vld;
  logic [DIV_STAGES-1:0] en;
  div_beat_t             st  [DIV_STAGES];
  logic [DIV_STAGES-1:0] quo [DIV_STAGES];

  logic [AMP_W:0] dvs;

  // divisor is twice the span above the threshold
  assign dvs = {ONE - {1'b0, cfg.threshold}, 1'b0};

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
    div_beat_t             src;
    logic [DIV_STAGES-1:0] src_q;
    logic                  src_v;
    logic [NUM_W-1:0]      trial;
    logic                  ge;
    div_beat_t             st_next;
    logic [DIV_STAGES-1:0] quo_next;

    if (i == 0) begin : g_first
      assign src   = in_data;
      assign src_q = '0;
      assign src_v = in_valid;
    end else begin : g_next
      assign src   = st[i-1];
      assign src_q = quo[i-1];
      assign src_v = vld[i-1];
    end

    if (i == DIV_STAGES - 1) begin : g_last
      assign en[i] = !vld[i] || out_ready;
    end else begin : g_mid
      assign en[i] = !vld[i] || en[i+1];
    end

    assign trial = NUM_W'(dvs) << (DIV_STAGES - 1 - i);
    assign ge    = src.numer >= trial;

    always_comb begin
      st_next  = src;
      quo_next = src_q;
      quo_next[DIV_STAGES-1-i] = ge;
      if (ge) begin
        st_next.numer = src.numer - trial;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en[i]) begin
        vld[i] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en[i]) begin
        st[i]  <= st_next;
        quo[i] <= quo_next;
      end
    end
  end

  assign in_ready          = en[0];
  assign out_valid         = vld[DIV_STAGES-1];
  assign out_data.alpha    = st[DIV_STAGES-1].covered ? quo[DIV_STAGES-1] : 8'd0;
  assign out_data.color    = st[DIV_STAGES-1].color;
  assign out_data.base     = st[DIV_STAGES-1].base;
  assign out_data.covered  = st[DIV_STAGES-1].covered;

endmodule

>>> hw/rtl/tcob_blend.sv
module tcob_blend import tcob_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  blend_beat_t in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output pixel_out_t  out_data
);

  logic v1, v2;
  logic en1, en2;

  logic [2:0][15:0] mix1;
  logic [7:0]       alpha1;
  logic             cov1;
  pixel_out_t       res2;

  logic [2:0][15:0] mix_c;
  logic [7:0]       inv_alpha;
  logic [2:0][31:0] q_c;

  assign en2      = !v2 || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  assign inv_alpha = 8'd255 - in_data.alpha;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mix_c[k] = ({8'd0, in_data.color[k]} * {8'd0, in_data.alpha})
               + ({8'd0, in_data.base[k]} * {8'd0, inv_alpha}) + 16'd127;
    end
  end

  // divide by 255 through the reciprocal
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      q_c[k] = {16'd0, mix1[k]} * {16'd0, BLEND_RECIP};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= in_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      mix1   <= mix_c;
      alpha1 <= in_data.alpha;
      cov1   <= in_data.covered;
    end
    if (en2) begin
      res2.out_red       <= q_c[2][BLEND_SHIFT+7:BLEND_SHIFT];
      res2.out_green     <= q_c[1][BLEND_SHIFT+7:BLEND_SHIFT];
      res2.out_blue      <= q_c[0][BLEND_SHIFT+7:BLEND_SHIFT];
      res2.overlay_alpha <= alpha1;
      res2.covered       <= cov1;
    end
  end

  assign out_valid = v2;
  assign out_data  = res2;

endmodule

>>> hw/rtl/threshold_colormap_overlay_blend_top.sv
// Threshold colormap overlay: one pixel beat in and one out per clock at full
// rate while out_ready stays high, pipelined as 3 front stages for amplitude,
// ramp colour and alpha numerator, 8 divider stages that resolve one alpha
// bit each and 2 blend stages. Every stage stalls on its own, so bubbles fill
// while the output waits. Registers are written through cfg_write /
// cfg_index / cfg_data and must only change while the pipeline is empty;
// threshold writes above 0.95 saturate.
module threshold_colormap_overlay_blend_top import tcob_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pixel_in_t             in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pixel_out_t            out_data
);

  cfg_t cfg;

  logic        f_valid, f_ready;
  div_beat_t   f_data;
  logic        d_valid, d_ready;
  blend_beat_t d_data;

  logic [VALUE_BITS-1:0] thr_in;

  assign thr_in = cfg_data[VALUE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.signed_mode <= 1'b0;
      cfg.opacity     <= 8'd255;
      cfg.threshold   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SIGNED_MODE: cfg.signed_mode <= cfg_data[0];
        REG_OPACITY:     cfg.opacity     <= cfg_data[7:0];
        REG_THRESHOLD:   cfg.threshold   <= (thr_in > THR_MAX) ? THR_MAX : thr_in;
        default: ;
      endcase
    end
  end

  tcob_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_data  (f_data)
  );

  tcob_div u_div (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_data  (d_data)
  );

  tcob_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .in_data   (d_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> verif/tb_threshold_colormap_overlay_blend_top.sv
`timescale 1ns / 1ps

module tb_threshold_colormap_overlay_blend_top;
  import tcob_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int FULL_SCALE = 1 << VALUE_BITS;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  pixel_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pixel_out_t out_data;

  // register copies seen by the blend predictor
  logic cur_mode = 1'b0;
  int cur_opacity = 255;
  int cur_thr = 0;

  pixel_in_t pixel_queue[$];
  pixel_out_t expected_pixels[$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  threshold_colormap_overlay_blend_top DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [23:0] ramp_color(logic mode, int idx);
    case (idx)
      0: return mode ? {8'd43, 8'd108, 8'd255} : {8'd25, 8'd185, 8'd220};
      1: return mode ? {8'd235, 8'd244, 8'd248} : {8'd255, 8'd221, 8'd72};
      default: return mode ? {8'd255, 8'd72, 8'd88} : {8'd255, 8'd77, 8'd66};
    endcase
  endfunction

  function automatic pixel_out_t blend_pixel(pixel_in_t px);
    pixel_out_t res;
    longint full, v, amp, den, alpha, tpos, lo, hi, mixed, ch;
    int seg;
    logic [23:0] from_c, to_c;
    logic [7:0] base_ch[3];
    logic [7:0] mix_ch[3];
    full = longint'(1) << VALUE_BITS;
    v = longint'(px.sample_value);
    base_ch[0] = px.base_red;
    base_ch[1] = px.base_green;
    base_ch[2] = px.base_blue;
    res = '0;
    res.out_red = px.base_red;
    res.out_green = px.base_green;
    res.out_blue = px.base_blue;
    if (cur_mode) begin
      amp = (2 * v >= full) ? 2 * v - full : full - 2 * v;
    end else begin
      amp = v;
    end
    if (amp <= cur_thr) return res;
    den = full - cur_thr;
    alpha = (2 * cur_opacity * (amp - cur_thr) + den) / (2 * den);
    if (alpha > 255) alpha = 255;
    seg = (v <= full / 2) ? 0 : 1;
    tpos = (seg == 0) ? 2 * v : 2 * v - full;
    from_c = ramp_color(cur_mode, seg);
    to_c = ramp_color(cur_mode, seg + 1);
    for (int k = 0; k < 3; k++) begin
      lo = from_c[23 - 8 * k -: 8];
      hi = to_c[23 - 8 * k -: 8];
      mixed = lo * full + tpos * (hi - lo);
      if (mixed < 0) mixed = 0;
      ch = (mixed + full / 2) / full;
      if (ch > 255) ch = 255;
      mix_ch[k] = 8'((ch * alpha + base_ch[k] * (255 - alpha) + 127) / 255);
    end
    res.out_red = mix_ch[0];
    res.out_green = mix_ch[1];
    res.out_blue = mix_ch[2];
    res.overlay_alpha = 8'(alpha);
    res.covered = 1'b1;
    return res;
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_sample();
    int half, amp, v;
    half = FULL_SCALE / 2;
    amp = 0;
    case ($urandom_range(7))
      0, 1, 2: v = int'($urandom_range(FULL_SCALE - 1));
      3: begin
        case ($urandom_range(5))
          0: v = 0;
          1: v = 1;
          2: v = half - 1;
          3: v = half;
          4: v = half + 1;
          default: v = FULL_SCALE - 1;
        endcase
      end
      default: begin
        // amplitude close to the threshold, or anywhere above it
        if ($urandom_range(1)) amp = cur_thr + int'($urandom_range(8)) - 4;
        else amp = int'($urandom_range(FULL_SCALE, cur_thr));
        if (cur_mode) v = $urandom_range(1) ? half + amp / 2 : half - amp / 2;
        else v = amp;
      end
    endcase
    if (v < 0) v = 0;
    if (v > FULL_SCALE - 1) v = FULL_SCALE - 1;
    return VALUE_BITS'(v);
  endfunction

  task automatic queue_pixel(logic [VALUE_BITS-1:0] v, logic [7:0] r, logic [7:0] g,
                             logic [7:0] b);
    pixel_in_t px;
    px.sample_value = v;
    px.base_red = r;
    px.base_green = g;
    px.base_blue = b;
    pixel_queue.push_back(px);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_SIGNED_MODE: cur_mode = val[0];
      REG_OPACITY: cur_opacity = int'(val[7:0]);
      REG_THRESHOLD: cur_thr = (val[VALUE_BITS-1:0] > THR_MAX) ? int'(THR_MAX)
                                                               : int'(val[VALUE_BITS-1:0]);
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pixel_queue.size() != 0 || in_valid || expected_pixels.size() != 0);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_pixels.push_back(blend_pixel(in_data));
      if (!in_valid || in_ready) begin
        if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= pixel_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    pixel_out_t exp_px;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 40)
            $display("%0t: unexpected beat, expected none, actual %h", $time, out_data);
        end else begin
          exp_px = expected_pixels.pop_front();
          if (out_data.out_red !== exp_px.out_red ||
              out_data.out_green !== exp_px.out_green ||
              out_data.out_blue !== exp_px.out_blue ||
              out_data.overlay_alpha !== exp_px.overlay_alpha ||
              out_data.covered !== exp_px.covered) begin
            mismatch_count++;
            if (mismatch_count <= 40)
              $display("%0t: rgb/alpha/cov expected %0d %0d %0d %0d %0d, actual %0d %0d %0d %0d %0d",
                       $time, exp_px.out_red, exp_px.out_green, exp_px.out_blue,
                       exp_px.overlay_alpha, exp_px.covered, out_data.out_red,
                       out_data.out_green, out_data.out_blue, out_data.overlay_alpha,
                       out_data.covered);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    int thr_val;
    logic [7:0] opa;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: unsigned ramp, opaque, zero threshold
    queue_pixel(16'h0000, 8'd0, 8'd0, 8'd0);
    queue_pixel(16'h0001, 8'd255, 8'd255, 8'd255);
    queue_pixel(16'h8000, 8'd255, 8'd0, 8'd255);
    queue_pixel(16'h8001, 8'd0, 8'd255, 8'd0);
    queue_pixel(16'hFFFF, 8'd37, 8'd200, 8'd91);

    // signed mode with upper data bits set, threshold write saturates
    wait_idle();
    write_reg(REG_SIGNED_MODE, 16'hFFFF);
    write_reg(REG_THRESHOLD, 16'hFFFF);
    @(negedge clk);
    queue_pixel(16'h0000, 8'd10, 8'd20, 8'd30);
    queue_pixel(16'h8000, 8'd255, 8'd255, 8'd255);
    queue_pixel(16'hFFFF, 8'd0, 8'd0, 8'd0);
    queue_pixel(16'h0001, 8'd128, 8'd64, 8'd32);
    queue_pixel(16'h7FFF, 8'd1, 8'd2, 8'd3);

    // zero opacity: covered but alpha stays 0
    wait_idle();
    write_reg(REG_OPACITY, 16'hAB00);
    @(negedge clk);
    queue_pixel(16'h0000, 8'd200, 8'd100, 8'd50);
    queue_pixel(16'hFFFF, 8'd255, 8'd0, 8'd128);

    // spare index ignored; tiny opacity, mid threshold
    wait_idle();
    write_reg(REG_SPARE, 16'h1234);
    write_reg(REG_SIGNED_MODE, 16'h0002);
    write_reg(REG_OPACITY, 16'h0001);
    write_reg(REG_THRESHOLD, 16'h8000);
    @(negedge clk);
    queue_pixel(16'h8001, 8'd90, 8'd180, 8'd45);
    queue_pixel(16'hFFFF, 8'd0, 8'd0, 8'd0);
    queue_pixel(16'h8000, 8'd255, 8'd255, 8'd255);
    queue_pixel(16'h7FFF, 8'd17, 8'd34, 8'd68);

    for (int phase = 0; phase < 10; phase++) begin
      wait_idle();
      write_reg(REG_SIGNED_MODE, CFG_DATA_W'($urandom));
      case ($urandom_range(2))
        0: opa = 8'd0;
        1: opa = 8'd255;
        default: opa = 8'($urandom);
      endcase
      write_reg(REG_OPACITY, CFG_DATA_W'({$urandom, opa}));
      case ($urandom_range(4))
        0: thr_val = 0;
        1: thr_val = int'(THR_MAX);
        2: thr_val = int'($urandom_range(FULL_SCALE - 1, int'(THR_MAX) + 1));
        3: thr_val = int'($urandom_range(THR_MAX));
        default: thr_val = int'($urandom_range(64));
      endcase
      write_reg(REG_THRESHOLD, CFG_DATA_W'(thr_val));
      @(negedge clk);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      repeat (125) queue_pixel(pick_sample(), 8'($urandom), 8'($urandom), 8'($urandom));
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
